// ===== rtl/text_console_character_writer_defines.svh =====
// assertion macros shared by the console writer rtl
// needs a clock named clock and a reset named reset in the using module
`ifndef TEXT_CONSOLE_CHARACTER_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHARACTER_WRITER_DEFINES_SVH

// condition must hold in every cycle out of reset
`define TCW_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// trigger implies the consequence in the next cycle
`define TCW_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// shared types and constants for the text console character writer
// no dependencies
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);

   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int LOC_W   = 11;
   localparam int WORD_W  = 16;
   localparam int COLOR_W = 4;
   localparam int CSR_IDX_W = 1;

   typedef logic [OP_W-1:0]      op_type;
   typedef logic [CHAR_W-1:0]    char_type;
   typedef logic [INDEX_W-1:0]   index_type;
   typedef logic [LOC_W-1:0]     loc_type;
   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [COLOR_W-1:0]   color_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [ADDR_W-1:0]    addr_type;

   localparam op_type OP_PUT   = 2'd0;
   localparam op_type OP_CLEAR = 2'd1;
   localparam op_type OP_READ  = 2'd2;

   localparam csr_index_type CSR_FG = 1'd0;
   localparam csr_index_type CSR_BG = 1'd1;

   localparam char_type CHR_BACKSPACE = 8'h08;
   localparam char_type CHR_NEWLINE   = 8'h0A;
   localparam char_type CHR_RETURN    = 8'h0D;
   localparam char_type CHR_SPACE     = 8'h20;
   localparam char_type CHR_FIRST_HI  = 8'h80;

   localparam color_type FG_RESET = 4'd15;
   localparam color_type BG_RESET = 4'd0;

   function automatic word_type make_cell(color_type bg, color_type fg, char_type ch);
      return {bg, fg, ch};
   endfunction

endpackage

// ===== rtl/tcw_if.sv =====
// request and response channel interfaces of the console writer
// depends on tcw_pkg
interface tcw_req_if;
   import tcw_pkg::*;
   logic      valid;
   logic      ready;
   op_type    operation;
   char_type  char_code;
   index_type cell_index;
   modport source (output valid, output operation, output char_code, output cell_index,
                   input ready);
   modport sink (input valid, input operation, input char_code, input cell_index,
                 output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic     valid;
   logic     ready;
   loc_type  cursor_location;
   word_type cell_word;
   modport source (output valid, output cursor_location, output cell_word, input ready);
   modport sink (input valid, input cursor_location, input cell_word, output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/text_console_character_writer.sv =====
// text console character writer: screen ram, cursor and operation sequencer
// depends on tcw_pkg, tcw_if, tcw_ram and the defines header
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    operation, char_code, cell_index
//   rsp_ch    out        valid/ready    cursor_location, cell_word
//   csr_*     in         write enable   csr_index, csr_wdata
//
// a put without scroll or an unused code goes straight to done
// a read passes the read state for the registered ram read; a scroll copies rows up, then
// blanks the bottom row, all on the one ram port pair, walked by a single address counter
// clear fills every cell with blanks before the result
// after reset a clearing pass writes blanks to every cell; req is not ready then
// one item at a time; a held result stalls the next result, not the next transfer
`include "text_console_character_writer_defines.svh"

module text_console_character_writer (
   input  logic                   clock,
   input  logic                   reset,
   tcw_req_if.sink                req_ch,
   tcw_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  tcw_pkg::csr_index_type csr_index,
   input  tcw_pkg::color_type     csr_wdata
);
   import tcw_pkg::*;

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_SCROLL = 6'b001000,
      ST_FILL   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   localparam addr_type SCROLL_LAST = ADDR_W'(CELLS - COLUMNS);
   localparam addr_type CELL_LAST   = ADDR_W'(CELLS - 1);
   localparam word_type RESET_BLANK = make_cell(BG_RESET, FG_RESET, CHR_SPACE);

   state_type state_ff, state_in;
   addr_type  cnt_ff, cnt_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   addr_type  loc_ff, loc_in;
   word_type  word_ff, word_in;
   logic      in_range_ff, in_range_in;
   color_type fg_ff, bg_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   loc_type   rsp_loc_ff, rsp_loc_in;
   word_type  rsp_word_ff, rsp_word_in;

   logic      ram_we;
   addr_type  ram_waddr, ram_raddr;
   word_type  ram_wdata, ram_rdata;

   logic      req_xfer;
   logic      last_row, last_col;
   addr_type  row_start;
   word_type  blank;
   char_type  ch;

   tcw_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.cursor_location = rsp_loc_ff;
   assign rsp_ch.cell_word       = rsp_word_ff;

   assign last_row  = (row_ff == ROW_W'(ROWS - 1));
   assign last_col  = (col_ff == COL_W'(COLUMNS - 1));
   assign row_start = loc_ff - ADDR_W'(col_ff);
   assign blank     = make_cell(bg_ff, fg_ff, CHR_SPACE);
   assign ch        = req_ch.char_code;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      loc_in       = loc_ff;
      word_in      = word_ff;
      in_range_in  = in_range_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_loc_in   = rsp_loc_ff;
      rsp_word_in  = rsp_word_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff;
      ram_wdata    = blank;
      // scroll source row sits one row below the destination
      ram_raddr    = cnt_ff + ADDR_W'(COLUMNS);

      unique case (state_ff)
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_wdata = RESET_BLANK;
            if (cnt_ff == CELL_LAST) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            ram_raddr = ADDR_W'(req_ch.cell_index);
            if (req_xfer) begin
               word_in  = '0;
               state_in = ST_DONE;
               cnt_in   = '0;
               case (req_ch.operation)
                  OP_PUT: begin
                     if (ch == CHR_NEWLINE) begin
                        col_in = '0;
                        if (last_row) begin
                           loc_in   = row_start;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in = row_ff + ROW_W'(1);
                           loc_in = row_start + ADDR_W'(COLUMNS);
                        end
                     end else if (ch == CHR_RETURN) begin
                        col_in = '0;
                        loc_in = row_start;
                     end else if (ch == CHR_BACKSPACE) begin
                        if (col_ff != '0) begin
                           col_in = col_ff - COL_W'(1);
                           loc_in = loc_ff - ADDR_W'(1);
                        end
                     end else if (ch >= CHR_SPACE && ch < CHR_FIRST_HI) begin
                        ram_we    = 1'b1;
                        ram_waddr = loc_ff;
                        ram_wdata = make_cell(bg_ff, fg_ff, ch);
                        if (last_col) begin
                           col_in = '0;
                           if (last_row) begin
                              loc_in   = row_start;
                              state_in = ST_SCROLL;
                           end else begin
                              row_in = row_ff + ROW_W'(1);
                              loc_in = loc_ff + ADDR_W'(1);
                           end
                        end else begin
                           col_in = col_ff + COL_W'(1);
                           loc_in = loc_ff + ADDR_W'(1);
                        end
                     end
                  end
                  OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     loc_in   = '0;
                     state_in = ST_FILL;
                  end
                  OP_READ: begin
                     in_range_in = (32'(req_ch.cell_index) < CELLS);
                     state_in    = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_READ: begin
            word_in  = in_range_ff ? ram_rdata : '0;
            state_in = ST_DONE;
         end
         ST_SCROLL: begin
            // read issued at cnt returns in the next cycle and is written at the new cnt-1
            if (cnt_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = cnt_ff - ADDR_W'(1);
               ram_wdata = ram_rdata;
            end
            if (cnt_ff == SCROLL_LAST) begin
               state_in = ST_FILL;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_FILL: begin
            ram_we = 1'b1;
            if (cnt_ff == CELL_LAST) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_loc_in   = LOC_W'(loc_ff);
               rsp_word_in  = word_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         loc_ff       <= '0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         loc_ff       <= loc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FG:  fg_ff <= csr_wdata;
               CSR_BG:  bg_ff <= csr_wdata;
               default: fg_ff <= fg_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      in_range_ff <= in_range_in;
      rsp_loc_ff  <= rsp_loc_in;
      rsp_word_ff <= rsp_word_in;
   end

   `TCW_ASSERT_ALWAYS(a_loc_matches_cursor,
      32'(loc_ff) == 32'(row_ff) * COLUMNS + 32'(col_ff),
      "linear cursor location out of step with row and column")
   `TCW_ASSERT_ALWAYS(a_cursor_in_range,
      (32'(col_ff) < COLUMNS) && (32'(row_ff) < ROWS),
      "cursor outside the screen")
   `TCW_ASSERT_ALWAYS(a_write_in_range,
      !ram_we || (32'(ram_waddr) < CELLS),
      "screen write beyond the last cell")
   `TCW_ASSERT_NEXT(a_busy_after_xfer, req_xfer, !req_ch.ready,
      "request taken again before the previous item finished")
   `TCW_ASSERT_NEXT(a_done_delivers, (state_ff == ST_DONE) && !rsp_valid_ff,
      rsp_valid_ff && (state_ff == ST_IDLE),
      "finished item did not reach the response register")

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the text console character writer
// keeps its own copy of screen, cursor and colors and checks every result in order
// depends on tcw_pkg, tcw_if and the rtl top text_console_character_writer
module testbench;
   import tcw_pkg::*;

   localparam longint LIMIT_TIME = 150_000_000;
   localparam op_type OP_UNUSED  = 2'd3;

   typedef struct packed {
      loc_type  location;
      word_type word;
   } console_result_type;

   class console_scoreboard;
      word_type           cells [CELLS];
      int unsigned        column;
      int unsigned        row;
      color_type          fg;
      color_type          bg;
      console_result_type pending_results [$];
      int unsigned        responses;
      int unsigned        errors;

      function new();
         fg = FG_RESET;
         bg = BG_RESET;
         fill_blanks(0, CELLS);
         column = 0;
         row = 0;
         responses = 0;
         errors = 0;
      endfunction

      function word_type cell_of(char_type ch);
         return {bg, fg, ch};
      endfunction

      function void fill_blanks(int unsigned from, int unsigned upto);
         for (int unsigned i = from; i < upto; i++) cells[i] = cell_of(CHR_SPACE);
      endfunction

      function void set_colors(color_type f, color_type b);
         fg = f;
         bg = b;
      endfunction

      function loc_type location();
         loc_type l;
         l = loc_type'(row * COLUMNS + column);
         return l;
      endfunction

      // scrolls when already on the bottom row
      function void next_row();
         column = 0;
         if (row + 1 >= ROWS) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
            fill_blanks(CELLS - COLUMNS, CELLS);
            row = ROWS - 1;
         end else begin
            row++;
         end
      endfunction

      function void put_char(char_type ch);
         if (ch == CHR_NEWLINE) begin
            next_row();
         end else if (ch == CHR_RETURN) begin
            column = 0;
         end else if (ch == CHR_BACKSPACE) begin
            if (column > 0) column--;
         end else if (ch >= CHR_SPACE && ch < CHR_FIRST_HI) begin
            cells[row * COLUMNS + column] = cell_of(ch);
            column++;
            if (column >= COLUMNS) next_row();
         end
      endfunction

      function void note_request(op_type op, char_type ch, index_type idx);
         console_result_type r;
         r.word = '0;
         case (op)
            OP_PUT: begin
               put_char(ch);
            end
            OP_CLEAR: begin
               fill_blanks(0, CELLS);
               column = 0;
               row = 0;
            end
            OP_READ: begin
               if (idx < CELLS) r.word = cells[idx];
            end
            default: ;
         endcase
         r.location = location();
         pending_results.push_back(r);
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("mismatch at %0t: %s", $time, msg);
      endtask

      task check_response(loc_type loc, word_type word);
         console_result_type r;
         responses++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending, loc %0d word %h",
                                      loc, word));
            return;
         end
         r = pending_results.pop_front();
         if (loc !== r.location)
            report_mismatch($sformatf("cursor_location %0d, predicted %0d", loc, r.location));
         if (word !== r.word)
            report_mismatch($sformatf("cell_word %h, predicted %h", word, r.word));
      endtask
   endclass

   logic          clock;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   color_type     csr_wdata;

   tcw_req_if req_ch();
   tcw_rsp_if rsp_ch();

   console_scoreboard sb = new;
   bit          idle_on = 1'b1;
   int unsigned sent = 0;

   text_console_character_writer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // results are checked before the same-edge transfer is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.cursor_location, rsp_ch.cell_word);
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.operation, req_ch.char_code, req_ch.cell_index);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   function automatic int unsigned stall_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // result side backpressure
   initial begin
      forever begin
         if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall_length()) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic send_item(op_type op, char_type ch, index_type idx);
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.char_code  <= ch;
      req_ch.cell_index <= idx;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic pause_requests();
      int unsigned n;
      n = pick_gap();
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic issue(op_type op, char_type ch, index_type idx);
      send_item(op, ch, idx);
      pause_requests();
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (sb.responses < sent) @(posedge clock);
   endtask

   task automatic write_colors(color_type f, color_type b);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_FG;
      csr_wdata <= f;
      @(posedge clock);
      csr_index <= CSR_BG;
      csr_wdata <= b;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_colors(f, b);
   endtask

   function automatic char_type printable();
      return char_type'($urandom_range(32, 127));
   endfunction

   // a run of text ended by newline or return, long enough at times to wrap
   task automatic type_line();
      int unsigned n;
      n = $urandom_range(1, 90);
      repeat (n) issue(OP_PUT, printable(), index_type'($urandom_range(0, 2047)));
      if ($urandom_range(0, 3) == 0) issue(OP_PUT, CHR_RETURN, '0);
      else issue(OP_PUT, CHR_NEWLINE, '0);
   endtask

   task automatic random_item();
      int unsigned r;
      int unsigned k;
      int unsigned loc;
      int unsigned back;
      char_type    ch;
      index_type   idx;
      r   = $urandom_range(0, 99);
      ch  = char_type'($urandom_range(0, 255));
      idx = index_type'($urandom_range(0, 2047));
      if (r < 2) begin
         issue(OP_CLEAR, ch, idx);
      end else if (r < 4) begin
         issue(OP_UNUSED, ch, idx);
      end else if (r < 20) begin
         k = $urandom_range(0, 9);
         if (k < 5) begin
            // read back what was just written near the cursor
            loc  = sb.location();
            back = $urandom_range(1, 6);
            idx  = index_type'(loc >= back ? loc - back : loc);
         end else if (k < 8) begin
            idx = index_type'($urandom_range(0, CELLS - 1));
         end
         issue(OP_READ, ch, idx);
      end else begin
         k = $urandom_range(0, 99);
         if (k < 68) ch = printable();
         else if (k < 78) ch = CHR_NEWLINE;
         else if (k < 83) ch = CHR_RETURN;
         else if (k < 88) ch = CHR_BACKSPACE;
         issue(OP_PUT, ch, idx);
      end
   endtask

   initial begin
      int unsigned target;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.operation  <= OP_PUT;
      req_ch.char_code  <= '0;
      req_ch.cell_index <= '0;
      csr_we            <= 1'b0;
      csr_index         <= CSR_FG;
      csr_wdata         <= FG_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset screen contents, range ends and the unused code
      issue(OP_READ, 8'h00, 11'd0);
      issue(OP_READ, 8'hFF, 11'd1999);
      issue(OP_READ, 8'h00, 11'h7FF);
      issue(OP_UNUSED, 8'hFF, 11'h7FF);
      // printable bounds, ignored high and control bytes
      issue(OP_PUT, 8'h41, '0);
      issue(OP_PUT, 8'h7F, '0);
      issue(OP_PUT, CHR_SPACE, '0);
      issue(OP_PUT, CHR_FIRST_HI, '0);
      issue(OP_PUT, 8'hFF, '0);
      issue(OP_PUT, 8'h00, '0);
      issue(OP_PUT, 8'h1F, '0);
      // backspace overwrite, return, backspace stuck at column zero, newline
      issue(OP_PUT, CHR_BACKSPACE, '0);
      issue(OP_PUT, CHR_BACKSPACE, '0);
      issue(OP_PUT, 8'h42, '0);
      issue(OP_PUT, CHR_RETURN, '0);
      issue(OP_PUT, CHR_BACKSPACE, '0);
      issue(OP_PUT, CHR_NEWLINE, '0);
      issue(OP_PUT, 8'h5A, '0);
      issue(OP_READ, '0, 11'd0);
      issue(OP_READ, '0, 11'd1);
      issue(OP_READ, '0, 11'd2);
      issue(OP_READ, '0, 11'd80);
      issue(OP_CLEAR, 8'hFF, 11'h7FF);
      issue(OP_READ, '0, 11'd0);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: write_colors(4'd0, 4'd0);
            1: write_colors(4'd15, 4'd15);
            2: write_colors(4'd0, 4'd15);
            default: write_colors(color_type'($urandom_range(0, 15)),
                                  color_type'($urandom_range(0, 15)));
         endcase
         idle_on = (p != 1);
         target = sent + 185;
         while (sent < target) begin
            if ($urandom_range(0, 9) == 0) type_line();
            else random_item();
            if ($urandom_range(0, 99) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_TIME);
      $display("simulation failed");
      $finish;
   end

endmodule
